// ===== sv/ssddf_pkg.sv =====
`default_nettype none

package ssddf_pkg;

   // datapath widths: box coordinates, multiplier operands, products
   localparam int DW = 21;
   localparam int MW = 22;
   localparam int PW = 2 * MW;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WANTED_LABEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE_ALIGN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_PARTIAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd5;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [10:0] WANTED_LABEL_ANY = 11'h7FF;
   localparam logic [13:0] IMAGE_WIDTH_RST  = 14'd640;
   localparam logic [13:0] IMAGE_HEIGHT_RST = 14'd480;

   // Q0.16 growth factors
   localparam logic [15:0] K_GROW_X = 16'd4391;
   localparam logic [15:0] K_GROW_Y = 16'd1835;
   localparam logic [15:0] K_GROW_W = 16'd9830;
   localparam logic [15:0] K_GROW_H = 16'd8520;

   // microprogram size
   localparam int UCODE_DEPTH = 18;
   localparam int STEP_W = $clog2(UCODE_DEPTH);

   // jump targets
   localparam logic [STEP_W-1:0] STEP_SQUARE = 5'd10;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 5'd17;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic [2:0] {
      MA_REL_L,
      MA_REL_R,
      MA_REL_T,
      MA_REL_B,
      MA_W,
      MA_H,
      MA_CW
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_IMG_W,
      MB_IMG_H,
      MB_K_X,
      MB_K_Y,
      MB_K_W,
      MB_K_H,
      MB_H,
      MB_CH
   } mul_b_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_LD_X,
      ALU_SUB_W,
      ALU_LD_Y,
      ALU_SUB_H,
      ALU_DEC_X,
      ALU_INC_W,
      ALU_DEC_Y,
      ALU_INC_H,
      ALU_SQUARE,
      ALU_CLIP_X,
      ALU_CLIP_Y,
      ALU_CLIP_FIN,
      ALU_AREA_SAVE,
      ALU_AREA_CMP,
      ALU_EMIT
   } alu_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_NO_ALIGN,
      JMP_NO_DROP
   } jump_type;

   typedef struct packed {
      logic              mul_en;
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      alu_op_type        alu;
      logic              sh16;
      jump_type          jmp;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucode_type;

   // control store: one word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{mul_en: 1'b0, mul_a: MA_REL_L, mul_b: MB_IMG_W, alu: ALU_NOP,
             sh16: 1'b0, jmp: JMP_NONE, target: '0, last: 1'b0};
      case (step)
         5'd0: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_REL_L; uc.mul_b = MB_IMG_W;
         end
         5'd1: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_REL_R; uc.mul_b = MB_IMG_W;
            uc.alu = ALU_LD_X;
         end
         5'd2: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_REL_T; uc.mul_b = MB_IMG_H;
            uc.alu = ALU_SUB_W;
         end
         5'd3: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_REL_B; uc.mul_b = MB_IMG_H;
            uc.alu = ALU_LD_Y;
         end
         5'd4: begin
            uc.alu = ALU_SUB_H; uc.jmp = JMP_NO_ALIGN; uc.target = STEP_SQUARE + 5'd1;
         end
         5'd5: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_W; uc.mul_b = MB_K_X;
         end
         5'd6: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_W; uc.mul_b = MB_K_W;
            uc.alu = ALU_DEC_X; uc.sh16 = 1'b1;
         end
         5'd7: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_H; uc.mul_b = MB_K_Y;
            uc.alu = ALU_INC_W; uc.sh16 = 1'b1;
         end
         5'd8: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_H; uc.mul_b = MB_K_H;
            uc.alu = ALU_DEC_Y; uc.sh16 = 1'b1;
         end
         5'd9: begin
            uc.alu = ALU_INC_H; uc.sh16 = 1'b1;
         end
         5'd10: uc.alu = ALU_SQUARE;
         5'd11: uc.alu = ALU_CLIP_X;
         5'd12: uc.alu = ALU_CLIP_Y;
         5'd13: begin
            uc.alu = ALU_CLIP_FIN; uc.jmp = JMP_NO_DROP; uc.target = STEP_EMIT;
         end
         5'd14: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_W; uc.mul_b = MB_H;
         end
         5'd15: begin
            uc.mul_en = 1'b1; uc.mul_a = MA_CW; uc.mul_b = MB_CH;
            uc.alu = ALU_AREA_SAVE;
         end
         5'd16: uc.alu = ALU_AREA_CMP;
         5'd17: begin
            uc.alu = ALU_EMIT; uc.last = 1'b1;
         end
         default: uc.last = 1'b1;
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ssd_detection_filter.sv =====
`default_nettype none

// SSD detection filter: one proposal in, at most one clipped box out. A proposal
// with req_end_marker closes the list and later proposals are ignored until one
// carries req_frame_start. Proposals failing the confidence or label filter are
// consumed with no result and the block stays idle. A kept proposal is worked by a
// small microprogram around one shared 22x22 signed multiplier, one step per cycle
// but for the wait at its last step; square alignment adds the grow and square
// steps, and dropping partial boxes adds the area check.
// A box that finds the previous one still stalled waits at its last step.
// The result waits in an output register, so the next proposal is taken while a
// box is still stalled on the rsp side. Configuration writes are accepted at
// any time (csr_ready is always high) but must only be issued while idle.
module ssd_detection_filter
   import ssddf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   // proposals
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_frame_start,
   input  wire logic                  req_end_marker,
   input  wire logic [9:0]            req_class_label,
   input  wire logic [15:0]           req_confidence,
   input  wire logic signed [15:0]    req_rel_left,
   input  wire logic signed [15:0]    req_rel_top,
   input  wire logic signed [15:0]    req_rel_right,
   input  wire logic signed [15:0]    req_rel_bottom,
   // boxes
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [13:0]                rsp_box_x,
   output logic [13:0]                rsp_box_y,
   output logic [13:0]                rsp_box_w,
   output logic [13:0]                rsp_box_h,
   output logic [9:0]                 rsp_out_label
);

   // configuration registers
   logic [15:0] conf_threshold_ff;
   logic [10:0] wanted_label_ff;
   logic        square_align_ff;
   logic        drop_partial_ff;
   logic [13:0] image_width_ff;
   logic [13:0] image_height_ff;
   logic        list_ended_ff, list_ended_in;

   // sequencer
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;

   // captured proposal
   logic signed [15:0] rel_l_ff, rel_t_ff, rel_r_ff, rel_b_ff;
   logic [9:0]         label_ff;

   // datapath
   logic signed [PW-1:0] p_ff, p_in, area_ff;
   logic signed [DW-1:0] x_ff, y_ff, w_ff, h_ff, cx_ff, cy_ff, cw_ff, ch_ff;
   logic                 okx_ff, oky_ff, keep_ff;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] bias, biased, shifted;
   logic signed [DW-1:0] t;
   logic signed [DW-1:0] lim_w, lim_h, lo, hi, span, diff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [9:0]  out_label_ff;

   logic accept, ended_now, label_ok, run, out_free, emit, jump;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ended_now = list_ended_ff && !req_frame_start;
   assign label_ok  = (wanted_label_ff == WANTED_LABEL_ANY) ||
                      (wanted_label_ff == {1'b0, req_class_label});
   assign run       = !req_end_marker && !ended_now &&
                      (req_confidence >= conf_threshold_ff) && label_ok;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign uc        = ucode_rom(step_ff);

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= '0;
         wanted_label_ff   <= WANTED_LABEL_ANY;
         square_align_ff   <= 1'b0;
         drop_partial_ff   <= 1'b0;
         image_width_ff    <= IMAGE_WIDTH_RST;
         image_height_ff   <= IMAGE_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_data;
            CSR_WANTED_LABEL:   wanted_label_ff   <= csr_data[10:0];
            CSR_SQUARE_ALIGN:   square_align_ff   <= csr_data[0];
            CSR_DROP_PARTIAL:   drop_partial_ff   <= csr_data[0];
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data[13:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   // track end of list
   always_comb begin
      list_ended_in = list_ended_ff;
      if (accept) begin
         list_ended_in = req_end_marker || ended_now;
      end
   end

   // sequence the microprogram
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      emit     = 1'b0;
      jump     = 1'b0;
      case (uc.jmp)
         JMP_NO_ALIGN: jump = !square_align_ff;
         JMP_NO_DROP:  jump = !drop_partial_ff;
         default:      jump = 1'b0;
      endcase
      case (state_ff)
         ST_IDLE: begin
            if (accept && run) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (uc.last) begin
               if (!keep_ff || out_free) begin
                  emit     = keep_ff && (uc.alu == ALU_EMIT);
                  state_in = ST_IDLE;
               end
            end else if (jump) begin
               step_in = uc.target;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         list_ended_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         list_ended_ff <= list_ended_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // select multiplier operands
   always_comb begin
      case (uc.mul_a)
         MA_REL_L: mul_a = MW'(rel_l_ff);
         MA_REL_R: mul_a = MW'(rel_r_ff);
         MA_REL_T: mul_a = MW'(rel_t_ff);
         MA_REL_B: mul_a = MW'(rel_b_ff);
         MA_W:     mul_a = MW'(w_ff);
         MA_H:     mul_a = MW'(h_ff);
         MA_CW:    mul_a = MW'(cw_ff);
         default:  mul_a = '0;
      endcase
      case (uc.mul_b)
         MB_IMG_W: mul_b = $signed({{(MW-14){1'b0}}, image_width_ff});
         MB_IMG_H: mul_b = $signed({{(MW-14){1'b0}}, image_height_ff});
         MB_K_X:   mul_b = $signed({{(MW-16){1'b0}}, K_GROW_X});
         MB_K_Y:   mul_b = $signed({{(MW-16){1'b0}}, K_GROW_Y});
         MB_K_W:   mul_b = $signed({{(MW-16){1'b0}}, K_GROW_W});
         MB_K_H:   mul_b = $signed({{(MW-16){1'b0}}, K_GROW_H});
         MB_H:     mul_b = MW'(h_ff);
         MB_CH:    mul_b = MW'(ch_ff);
         default:  mul_b = '0;
      endcase
      p_in = mul_a * mul_b;
   end

   // truncate the product toward zero by 2^14 or 2^16
   always_comb begin
      bias = '0;
      if (p_ff[PW-1]) begin
         bias = uc.sh16 ? $signed({{(PW-16){1'b0}}, 16'hFFFF})
                        : $signed({{(PW-14){1'b0}}, 14'h3FFF});
      end
      biased  = p_ff + bias;
      shifted = uc.sh16 ? (biased >>> 16) : (biased >>> 14);
      t       = shifted[DW-1:0];
   end

   // clip one axis: lo = max(pos,0), hi = min(pos+size,limit)
   assign lim_w = $signed({{(DW-14){1'b0}}, image_width_ff});
   assign lim_h = $signed({{(DW-14){1'b0}}, image_height_ff});
   always_comb begin
      if (uc.alu == ALU_CLIP_Y) begin
         lo = (y_ff < 0) ? '0 : y_ff;
         hi = ((y_ff + h_ff) < lim_h) ? (y_ff + h_ff) : lim_h;
      end else begin
         lo = (x_ff < 0) ? '0 : x_ff;
         hi = ((x_ff + w_ff) < lim_w) ? (x_ff + w_ff) : lim_w;
      end
      span = hi - lo;
      diff = (w_ff < h_ff) ? (h_ff - w_ff) : (w_ff - h_ff);
   end

   // capture proposal, run datapath step
   always_ff @(posedge clock) begin
      if (accept && run) begin
         rel_l_ff <= req_rel_left;
         rel_t_ff <= req_rel_top;
         rel_r_ff <= req_rel_right;
         rel_b_ff <= req_rel_bottom;
         label_ff <= req_class_label;
         keep_ff  <= 1'b1;
      end
      if (state_ff == ST_RUN) begin
         if (uc.mul_en) begin
            p_ff <= p_in;
         end
         case (uc.alu)
            ALU_LD_X:  x_ff <= t;
            ALU_SUB_W: w_ff <= t - x_ff;
            ALU_LD_Y:  y_ff <= t;
            ALU_SUB_H: h_ff <= t - y_ff;
            ALU_DEC_X: x_ff <= x_ff - t;
            ALU_INC_W: w_ff <= w_ff + t;
            ALU_DEC_Y: y_ff <= y_ff - t;
            ALU_INC_H: h_ff <= h_ff + t;
            ALU_SQUARE: begin
               if (w_ff < h_ff) begin
                  x_ff <= x_ff - (diff >>> 1);
                  w_ff <= h_ff;
               end else begin
                  y_ff <= y_ff - (diff >>> 1);
                  h_ff <= w_ff;
               end
            end
            ALU_CLIP_X: begin
               cx_ff  <= lo;
               cw_ff  <= span;
               okx_ff <= (span > 0) && (w_ff > 0);
            end
            ALU_CLIP_Y: begin
               cy_ff  <= lo;
               ch_ff  <= span;
               oky_ff <= (span > 0) && (h_ff > 0);
            end
            ALU_CLIP_FIN: begin
               if (!(okx_ff && oky_ff)) begin
                  cx_ff <= '0;
                  cy_ff <= '0;
                  cw_ff <= '0;
                  ch_ff <= '0;
               end
            end
            ALU_AREA_SAVE: area_ff <= p_ff;
            ALU_AREA_CMP:  keep_ff <= (p_ff == area_ff);
            default: ;
         endcase
      end
   end

   // hold the result until transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         box_x_ff     <= cx_ff[13:0];
         box_y_ff     <= cy_ff[13:0];
         box_w_ff     <= cw_ff[13:0];
         box_h_ff     <= ch_ff[13:0];
         out_label_ff <= label_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_box_x     = box_x_ff;
   assign rsp_box_y     = box_y_ff;
   assign rsp_box_w     = box_w_ff;
   assign rsp_box_h     = box_h_ff;
   assign rsp_out_label = out_label_ff;

endmodule

`default_nettype wire

// ===== tb/ssd_detection_filter_tb.sv =====
module ssd_detection_filter_tb
   import ssddf_pkg::*;
();

   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int DRAIN_PAD   = 40;
   localparam int DRAIN_LIMIT = 5000;
   localparam int LONG_HOLD   = 400;

   // Q0.16 growth factors of the square alignment
   localparam longint GROW_X = 4391;
   localparam longint GROW_Y = 1835;
   localparam longint GROW_W = 9830;
   localparam longint GROW_H = 8520;

   typedef struct packed {
      logic               frame_start;
      logic               end_marker;
      logic [9:0]         class_label;
      logic [15:0]        confidence;
      logic signed [15:0] rel_left;
      logic signed [15:0] rel_top;
      logic signed [15:0] rel_right;
      logic signed [15:0] rel_bottom;
   } prop_type;

   typedef struct packed {
      logic [13:0] x;
      logic [13:0] y;
      logic [13:0] w;
      logic [13:0] h;
      logic [9:0]  label;
   } box_type;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      prop_type              prop;
      bit                    typed;
      bit                    keeps;
      box_type               box;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_frame_start = 1'b0;
   logic                  req_end_marker = 1'b0;
   logic [9:0]            req_class_label = '0;
   logic [15:0]           req_confidence = '0;
   logic signed [15:0]    req_rel_left = '0;
   logic signed [15:0]    req_rel_top = '0;
   logic signed [15:0]    req_rel_right = '0;
   logic signed [15:0]    req_rel_bottom = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [13:0]           rsp_box_x;
   logic [13:0]           rsp_box_y;
   logic [13:0]           rsp_box_w;
   logic [13:0]           rsp_box_h;
   logic [9:0]            rsp_out_label;

   // predicted register file and list state
   logic [15:0]        cfg_thresh = 16'd0;
   logic signed [10:0] cfg_label  = -11'sd1;
   logic               cfg_square = 1'b0;
   logic               cfg_drop   = 1'b0;
   logic [13:0]        cfg_width  = 14'd640;
   logic [13:0]        cfg_height = 14'd480;
   logic               list_closed = 1'b0;

   box_type      pending_boxes[$];
   stim_row_type directed_rows[$];
   int           errors = 0;
   bit           calm = 1'b0;
   bit           long_hold_req = 1'b0;
   bit           hold_fired = 1'b0;
   prop_type     stim;
   box_type      got_box;
   box_type      want_box;
   int           ph;
   int           count;

   ssd_detection_filter DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_frame_start(req_frame_start),
      .req_end_marker(req_end_marker),
      .req_class_label(req_class_label),
      .req_confidence(req_confidence),
      .req_rel_left(req_rel_left),
      .req_rel_top(req_rel_top),
      .req_rel_right(req_rel_right),
      .req_rel_bottom(req_rel_bottom),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_box_x(rsp_box_x),
      .rsp_box_y(rsp_box_y),
      .rsp_box_w(rsp_box_w),
      .rsp_box_h(rsp_box_h),
      .rsp_out_label(rsp_out_label)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror a register write into the predicted register file
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_CONF_THRESHOLD: cfg_thresh = val[15:0];
         CSR_WANTED_LABEL:   cfg_label  = val[10:0];
         CSR_SQUARE_ALIGN:   cfg_square = val[0];
         CSR_DROP_PARTIAL:   cfg_drop   = val[0];
         CSR_IMAGE_WIDTH:    cfg_width  = val[13:0];
         CSR_IMAGE_HEIGHT:   cfg_height = val[13:0];
         default: ;
      endcase
   endfunction

   // filter one proposal and form its clipped box; returns 1 when a box comes out
   function automatic bit filter_proposal(input prop_type p, output box_type bx);
      longint iw, ih, want, x, y, w, h, w0, h0, d, x1, y1, nw, nh, cx, cy, cw, ch;
      bx = '0;
      iw = longint'(cfg_width);
      ih = longint'(cfg_height);
      want = longint'(cfg_label);
      if (p.frame_start) list_closed = 1'b0;
      if (p.end_marker) begin
         list_closed = 1'b1;
         return 1'b0;
      end
      if (list_closed) return 1'b0;
      if (p.confidence < cfg_thresh) return 1'b0;
      if (want != -1 && longint'(p.class_label) != want) return 1'b0;

      // scale relative corners to pixels
      x = (longint'(p.rel_left) * iw) / 16384;
      y = (longint'(p.rel_top) * ih) / 16384;
      w = (longint'(p.rel_right) * iw) / 16384 - x;
      h = (longint'(p.rel_bottom) * ih) / 16384 - y;

      // grow, then pad the short side to a square
      if (cfg_square) begin
         w0 = w;
         h0 = h;
         x -= (GROW_X * w0) / 65536;
         y -= (GROW_Y * h0) / 65536;
         w += (GROW_W * w0) / 65536;
         h += (GROW_H * h0) / 65536;
         if (w < h) begin
            d = h - w;
            x -= d / 2;
            w += d;
         end else begin
            d = w - h;
            y -= d / 2;
            h += d;
         end
      end

      // intersect with the image, empty gives the zero box
      cx = 0; cy = 0; cw = 0; ch = 0;
      if (w > 0 && h > 0 && iw > 0 && ih > 0) begin
         x1 = (x > 0) ? x : 0;
         y1 = (y > 0) ? y : 0;
         nw = (((x + w) < iw) ? (x + w) : iw) - x1;
         nh = (((y + h) < ih) ? (y + h) : ih) - y1;
         if (nw > 0 && nh > 0) begin
            cx = x1; cy = y1; cw = nw; ch = nh;
         end
      end
      if (cfg_drop && cw * ch != w * h) return 1'b0;

      bx.x = cx[13:0];
      bx.y = cy[13:0];
      bx.w = cw[13:0];
      bx.h = ch[13:0];
      bx.label = p.class_label;
      return 1'b1;
   endfunction

   function automatic prop_type mk_prop(input int fs, input int em, input int lbl, input int conf,
                                        input int l, input int t, input int r, input int b);
      prop_type p;
      p.frame_start = fs[0];
      p.end_marker  = em[0];
      p.class_label = lbl[9:0];
      p.confidence  = conf[15:0];
      p.rel_left    = l[15:0];
      p.rel_top     = t[15:0];
      p.rel_right   = r[15:0];
      p.rel_bottom  = b[15:0];
      return p;
   endfunction

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row = '{is_cfg: 1'b1, idx: idx, data: val, prop: '0, typed: 1'b0, keeps: 1'b0,
              box: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input prop_type p);
      stim_row_type row;
      row = '{is_cfg: 1'b0, idx: '0, data: '0, prop: p, typed: 1'b0, keeps: 1'b0, box: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(input prop_type p, input bit keeps, input box_type bx);
      stim_row_type row;
      row = '{is_cfg: 1'b0, idx: '0, data: '0, prop: p, typed: 1'b1, keeps: keeps, box: bx};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [13:0] rand_size();
      case ($urandom_range(0, 15))
         0, 1:    return 14'd1;
         2, 3:    return 14'd8192;
         4:       return 14'd0;
         5:       return 14'd16383;
         default: return 14'($urandom_range(1, 8192));
      endcase
   endfunction

   // one edge pair: mostly ordered inside the image, some outside, some raw
   function automatic void rand_span(output logic signed [15:0] lo,
                                     output logic signed [15:0] hi);
      int a, b;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            a = $urandom;
            b = $urandom;
         end
         3: begin
            a = int'($urandom_range(0, 20000)) - 2000;
            b = int'($urandom_range(0, 20000)) - 2000;
         end
         default: begin
            a = $urandom_range(0, 16000);
            b = a + int'($urandom_range(1, 16384 - a));
         end
      endcase
      lo = a[15:0];
      hi = b[15:0];
   endfunction

   function automatic void report_field(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // write one register and mirror it once the transfer completes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] thr, input logic signed [10:0] lbl,
                             input logic sq, input logic drop,
                             input logic [13:0] iw, input logic [13:0] ih);
      write_reg(CSR_CONF_THRESHOLD, thr);
      write_reg(CSR_WANTED_LABEL, {5'b0, lbl});
      write_reg(CSR_SQUARE_ALIGN, {15'b0, sq});
      write_reg(CSR_DROP_PARTIAL, {15'b0, drop});
      write_reg(CSR_IMAGE_WIDTH, {2'b0, iw});
      write_reg(CSR_IMAGE_HEIGHT, {2'b0, ih});
   endtask

   // offer one proposal, hold it until the transfer, then queue its box
   task automatic send_proposal(input prop_type p, input bit typed, input bit keeps,
                                input box_type bx);
      bit      kept;
      box_type pbox;
      req_valid       <= 1'b1;
      req_frame_start <= p.frame_start;
      req_end_marker  <= p.end_marker;
      req_class_label <= p.class_label;
      req_confidence  <= p.confidence;
      req_rel_left    <= p.rel_left;
      req_rel_top     <= p.rel_top;
      req_rel_right   <= p.rel_right;
      req_rel_bottom  <= p.rel_bottom;
      do @(posedge clock); while (req_stall);
      kept = filter_proposal(p, pbox);
      if (typed) begin
         kept = keeps;
         pbox = bx;
      end
      if (kept) pending_boxes.push_back(pbox);
   endtask

   task automatic idle_sender();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // wait for every queued box, then let the pipeline empty
   task automatic wait_drained();
      int spins;
      spins = 0;
      while (pending_boxes.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      if (pending_boxes.size() != 0) begin
         $display("%0t: %0d expected boxes never arrived", $time, pending_boxes.size());
         errors += pending_boxes.size();
         pending_boxes.delete();
      end
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // receiver: random stall bursts, one long hold on request, none when calm
   initial begin
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // check each box transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_box = '{rsp_box_x, rsp_box_y, rsp_box_w, rsp_box_h, rsp_out_label};
         if (pending_boxes.size() == 0) begin
            $display("%0t: unexpected box, expected none, actual x=%0d y=%0d w=%0d h=%0d l=%0d",
                     $time, got_box.x, got_box.y, got_box.w, got_box.h, got_box.label);
            errors++;
         end else begin
            want_box = pending_boxes.pop_front();
            report_field("box_x", want_box.x, got_box.x);
            report_field("box_y", want_box.y, got_box.y);
            report_field("box_w", want_box.w, got_box.w);
            report_field("box_h", want_box.h, got_box.h);
            report_field("out_label", want_box.label, got_box.label);
         end
      end
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      // directed rows: reset settings first
      add_known(mk_prop(1, 0, 5, 100, 0, 0, 16384, 16384), 1,
                box_type'{14'd0, 14'd0, 14'd640, 14'd480, 10'd5});
      add_known(mk_prop(0, 0, 1023, 65535, 8192, 8192, 16384, 16384), 1,
                box_type'{14'd320, 14'd240, 14'd320, 14'd240, 10'd1023});
      add_known(mk_prop(0, 0, 0, 0, 4096, 4096, 4096, 4096), 1, '0);
      add_known(mk_prop(0, 0, 7, 500, -32768, -32768, 32767, 32767), 1,
                box_type'{14'd0, 14'd0, 14'd640, 14'd480, 10'd7});
      add_known(mk_prop(0, 0, 9, 500, -32768, -32768, -32768, -32768), 1,
                box_type'{14'd0, 14'd0, 14'd0, 14'd0, 10'd9});
      add_known(mk_prop(0, 0, 11, 500, 32767, 32767, 32767, 32767), 1,
                box_type'{14'd0, 14'd0, 14'd0, 14'd0, 10'd11});
      add_known(mk_prop(0, 0, 2, 500, 16384, 0, 0, 16384), 1,
                box_type'{14'd0, 14'd0, 14'd0, 14'd0, 10'd2});
      add_item(mk_prop(0, 0, 3, 900, 1000, 2000, 9000, 15000));
      // end of list, ignored item, reopen-and-end, then a fresh frame
      add_known(mk_prop(0, 1, 4, 900, 0, 0, 16384, 16384), 0, '0);
      add_known(mk_prop(0, 0, 4, 900, 0, 0, 16384, 16384), 0, '0);
      add_known(mk_prop(1, 1, 4, 900, 0, 0, 16384, 16384), 0, '0);
      add_known(mk_prop(0, 0, 4, 900, 0, 0, 16384, 16384), 0, '0);
      add_item(mk_prop(1, 0, 6, 900, 3000, 1000, 12000, 9000));
      // confidence threshold and label filter at their extremes
      add_cfg(CSR_CONF_THRESHOLD, 16'hFFFF);
      add_cfg(CSR_WANTED_LABEL, 16'h03FF);
      add_known(mk_prop(0, 0, 1023, 65534, 0, 0, 16384, 16384), 0, '0);
      add_known(mk_prop(0, 0, 1023, 65535, 0, 0, 16384, 16384), 1,
                box_type'{14'd0, 14'd0, 14'd640, 14'd480, 10'd1023});
      add_known(mk_prop(0, 0, 1022, 65535, 0, 0, 16384, 16384), 0, '0);
      // a negative label other than the wildcard passes nothing
      add_cfg(CSR_CONF_THRESHOLD, 16'h0000);
      add_cfg(CSR_WANTED_LABEL, 16'h07FE);
      add_known(mk_prop(0, 0, 0, 900, 0, 0, 16384, 16384), 0, '0);
      add_known(mk_prop(0, 0, 1022, 900, 0, 0, 16384, 16384), 0, '0);
      // square alignment with partial drop on a large image
      add_cfg(CSR_WANTED_LABEL, 16'h07FF);
      add_cfg(CSR_SQUARE_ALIGN, 16'h0001);
      add_cfg(CSR_DROP_PARTIAL, 16'h0001);
      add_cfg(CSR_IMAGE_WIDTH, 16'd8192);
      add_cfg(CSR_IMAGE_HEIGHT, 16'd8192);
      add_item(mk_prop(0, 0, 12, 900, 4096, 4096, 8192, 12288));
      add_item(mk_prop(0, 0, 13, 900, 0, 0, 4096, 4096));
      // zero image: every box is the zero box and zero area passes the drop
      add_cfg(CSR_SQUARE_ALIGN, 16'h0000);
      add_cfg(CSR_IMAGE_WIDTH, 16'd0);
      add_cfg(CSR_IMAGE_HEIGHT, 16'd0);
      add_known(mk_prop(0, 0, 14, 900, 0, 0, 0, 0), 1,
                box_type'{14'd0, 14'd0, 14'd0, 14'd0, 10'd14});
      add_known(mk_prop(0, 0, 15, 900, -32768, -32768, 32767, 32767), 1,
                box_type'{14'd0, 14'd0, 14'd0, 14'd0, 10'd15});
      // image sizes beyond 8192 and the smallest one
      add_cfg(CSR_DROP_PARTIAL, 16'h0000);
      add_cfg(CSR_IMAGE_WIDTH, 16'd16383);
      add_cfg(CSR_IMAGE_HEIGHT, 16'd16383);
      add_item(mk_prop(0, 0, 16, 900, -32768, -32768, 32767, 32767));
      add_cfg(CSR_IMAGE_WIDTH, 16'd1);
      add_cfg(CSR_IMAGE_HEIGHT, 16'd1);
      add_item(mk_prop(0, 0, 17, 900, 0, 0, 32767, 32767));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            req_valid <= 1'b0;
            wait_drained();
            write_reg(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_proposal(directed_rows[i].prop, directed_rows[i].typed,
                          directed_rows[i].keeps, directed_rows[i].box);
            idle_sender();
         end
      end

      // random phases, each with its own register settings
      for (ph = 0; ph < N_PHASES; ph++) begin
         req_valid <= 1'b0;
         wait_drained();
         calm = (ph == N_PHASES - 1);
         case (ph)
            0: set_config(16'd0, -11'sd1, 1'b0, 1'b0, 14'd640, 14'd480);
            1: set_config(16'd0, -11'sd1, 1'b1, 1'b0, 14'd8192, 14'd8192);
            2: set_config(16'h8000, -11'sd1, 1'b1, 1'b1, 14'd1, 14'd1);
            3: set_config(16'd0, 11'($urandom_range(0, 1023)), 1'b0, 1'b1,
                          rand_size(), rand_size());
            4: set_config(16'hFFFF, -11'sd1, 1'b0, 1'b0, 14'd16383, 14'd0);
            default: set_config(16'($urandom_range(0, 40000)),
                                ($urandom_range(0, 1) == 0) ? -11'sd1 :
                                ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 1023)) :
                                11'($urandom),
                                1'($urandom), 1'($urandom), rand_size(), rand_size());
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            // fill the block while the receiver holds off
            if (ph == 3 && count == 40 && !hold_fired) begin
               hold_fired = 1'b1;
               long_hold_req = 1'b1;
            end
            case ($urandom_range(0, 7))
               0, 1:    stim.confidence = 16'hFFFF;
               2:       stim.confidence = 16'h0000;
               default: stim.confidence = 16'($urandom);
            endcase
            if (cfg_label >= 0 && $urandom_range(0, 1) == 1)
               stim.class_label = cfg_label[9:0];
            else
               stim.class_label = 10'($urandom);
            rand_span(stim.rel_left, stim.rel_right);
            rand_span(stim.rel_top, stim.rel_bottom);
            if (list_closed) begin
               if ($urandom_range(0, 3) == 0) begin
                  // noise after the end of list, ignored by the block
                  stim.frame_start = 1'b0;
                  stim.end_marker  = 1'($urandom);
               end else begin
                  stim.frame_start = 1'b1;
                  stim.end_marker  = ($urandom_range(0, 15) == 0);
                  count++;
               end
            end else begin
               stim.frame_start = ($urandom_range(0, 19) == 0);
               stim.end_marker  = ($urandom_range(0, 24) == 0);
               count++;
            end
            send_proposal(stim, 1'b0, 1'b0, '0);
            idle_sender();
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ssddf_pkg.sv
sv/ssd_detection_filter.sv
tb/ssd_detection_filter_tb.sv
